[hdl/contact_normal_selector_assert.svh]
// assertion macros for the checker
`ifndef CONTACT_NORMAL_SELECTOR_ASSERT_SVH
`define CONTACT_NORMAL_SELECTOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define CNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cns_pkg.sv]
package cns_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int NORM_W     = FRAC_BITS + 2;
    localparam int DEPTH_W    = 31;
    localparam int VEC_W      = DATA_W + 2;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int DVD_W      = DATA_W + FRAC_BITS;
    localparam int DOT_W      = 2 * NORM_W + 2;
    localparam int SCORE_W    = DATA_W + 2;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = DVD_W;

    localparam logic [SQ_W-1:0] NEAR_ZERO_SQ =
        SQ_W'((64'd1 << (2 * FRAC_BITS)) / 64'd10000000000);
    localparam logic signed [SCORE_W:0] SCORE_MARGIN =
        (SCORE_W + 1)'((64'd1 << FRAC_BITS) / 64'd10000);
    localparam logic [DVD_W-1:0] ONE_RAW = DVD_W'(64'd1 << FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_Z = 2'd3;

    localparam logic [1:0] FUNC_BEGIN   = 2'd0;
    localparam logic [1:0] FUNC_CONTACT = 2'd1;
    localparam logic [1:0] FUNC_RESOLVE = 2'd2;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_BEGIN     = 4'd1;
    localparam logic [3:0] OP_MARK      = 4'd2;
    localparam logic [3:0] OP_SQ        = 4'd3;
    localparam logic [3:0] OP_SQRT_INIT = 4'd4;
    localparam logic [3:0] OP_SQRT_STEP = 4'd5;
    localparam logic [3:0] OP_DIV_INIT  = 4'd6;
    localparam logic [3:0] OP_DIV_STEP  = 4'd7;
    localparam logic [3:0] OP_DIV_STORE = 4'd8;
    localparam logic [3:0] OP_SET_MDIR  = 4'd9;
    localparam logic [3:0] OP_DOT       = 4'd10;
    localparam logic [3:0] OP_SCORE     = 4'd11;
    localparam logic [3:0] OP_EMIT      = 4'd12;

    localparam logic [1:0] EMIT_ZERO     = 2'd0;
    localparam logic [1:0] EMIT_BEST     = 2'd1;
    localparam logic [1:0] EMIT_UNIT     = 2'd2;
    localparam logic [1:0] EMIT_BLK_ZERO = 2'd3;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
        logic [1:0] idx;
        logic [1:0] emit_kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       depth_neg;
        logic       depth_le_tol;
        logic       world;
        logic       seen;
        logic       deepest_le_tol;
        logic       have_blk;
        logic       s_small;
        logic       len_le_tol;
        logic       out_full;
    } status_t;

    function automatic logic [VEC_W-1:0] mag_f(input logic signed [VEC_W-1:0] v);
        return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    endfunction

endpackage

[hdl/contact_normal_selector.sv]
// contact normal selector: chooses the surface normal that blocks a hand from a set of
// contacts, input values q16.16 and unit normals q2.16. a begin transfer clears the
// summary and normalises the motion registers; contact transfers are scored against
// that direction; a resolve transfer yields one blocking decision. one item at a time:
// the square root runs two bits per cycle and each unit component comes from a
// restoring divider with a set-up and a store step. the result sits in an output
// register, so the next transfer is taken while it waits; a resolve only stalls if the
// previous result is still held. the user must write the configuration port only while
// the block is idle; the block itself does not enforce it. tolerance is read live.
module contact_normal_selector (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [cns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cns_pkg::DATA_W-1:0]         cfg_wr_data,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_func,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_contact_depth,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_contact_normal_x,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_contact_normal_y,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_contact_normal_z,
    input  logic                               s_world_collided,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_requested_x,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_requested_y,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_requested_z,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_corrected_x,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_corrected_y,
    input  logic signed [cns_pkg::DATA_W-1:0]  s_corrected_z,
    // blocking decisions
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_blocking,
    output logic signed [cns_pkg::NORM_W-1:0]  m_push_normal_x,
    output logic signed [cns_pkg::NORM_W-1:0]  m_push_normal_y,
    output logic signed [cns_pkg::NORM_W-1:0]  m_push_normal_z,
    output logic [cns_pkg::DEPTH_W-1:0]        m_push_depth
);
    import cns_pkg::*;

    // command from the sequencer, status back from the datapath
    cmd_t    cmd;
    status_t st;

    // sequencer: decides the path of each item and steps the shared units
    cns_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // datapath: registers, squaring, root, divider, dot product and result register
    cns_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .st                 (st),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_func             (s_func),
        .s_contact_depth    (s_contact_depth),
        .s_contact_normal_x (s_contact_normal_x),
        .s_contact_normal_y (s_contact_normal_y),
        .s_contact_normal_z (s_contact_normal_z),
        .s_world_collided   (s_world_collided),
        .s_requested_x      (s_requested_x),
        .s_requested_y      (s_requested_y),
        .s_requested_z      (s_requested_z),
        .s_corrected_x      (s_corrected_x),
        .s_corrected_y      (s_corrected_y),
        .s_corrected_z      (s_corrected_z),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_blocking         (m_blocking),
        .m_push_normal_x    (m_push_normal_x),
        .m_push_normal_y    (m_push_normal_y),
        .m_push_normal_z    (m_push_normal_z),
        .m_push_depth       (m_push_depth)
    );

endmodule

[hdl/cns_controller.sv]
module cns_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cns_pkg::status_t st,
    output cns_pkg::cmd_t    cmd
);
    import cns_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SQ     = 4'd2;
    localparam logic [3:0] S_SQRT_I = 4'd3;
    localparam logic [3:0] S_SQRT   = 4'd4;
    localparam logic [3:0] S_POST   = 4'd5;
    localparam logic [3:0] S_DIV_I  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DIV_W  = 4'd8;
    localparam logic [3:0] S_SETMD  = 4'd9;
    localparam logic [3:0] S_DOT    = 4'd10;
    localparam logic [3:0] S_SCORE  = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       kind_reg, kind_next;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            kind_reg  <= EMIT_ZERO;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        kind_next     = kind_reg;
        cmd.load      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.idx       = idx_reg;
        cmd.emit_kind = kind_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                idx_next = '0;
                unique case (st.func)
                    FUNC_BEGIN: begin
                        cmd.op     = OP_BEGIN;
                        state_next = S_SQ;
                    end
                    FUNC_CONTACT: begin
                        if (st.depth_neg) begin
                            state_next = S_IDLE;
                        end else begin
                            cmd.op     = OP_MARK;
                            state_next = st.depth_le_tol ? S_IDLE : S_SQ;
                        end
                    end
                    FUNC_RESOLVE: begin
                        if (!st.world || (st.seen && st.deepest_le_tol)) begin
                            kind_next  = EMIT_ZERO;
                            state_next = S_EMIT;
                        end else if (st.seen && st.have_blk) begin
                            kind_next  = EMIT_BEST;
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_SQ;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SQ: begin
                cmd.op   = OP_SQ;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    state_next = S_SQRT_I;
                end
            end
            S_SQRT_I: begin
                if (st.s_small && st.func != FUNC_RESOLVE) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.op     = OP_SQRT_INIT;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                idx_next = '0;
                if (st.func == FUNC_RESOLVE && st.len_le_tol) begin
                    kind_next  = EMIT_ZERO;
                    state_next = S_EMIT;
                end else if (st.func == FUNC_RESOLVE && st.s_small) begin
                    kind_next  = EMIT_BLK_ZERO;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_DIV_I;
                end
            end
            S_DIV_I: begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_DIV_W;
                end
            end
            S_DIV_W: begin
                cmd.op = OP_DIV_STORE;
                if (idx_reg == 2'd2) begin
                    idx_next = '0;
                    priority case (st.func)
                        FUNC_BEGIN:   state_next = S_SETMD;
                        FUNC_CONTACT: state_next = S_DOT;
                        default: begin
                            kind_next  = EMIT_UNIT;
                            state_next = S_EMIT;
                        end
                    endcase
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_DIV_I;
                end
            end
            S_SETMD: begin
                cmd.op     = OP_SET_MDIR;
                state_next = S_IDLE;
            end
            S_DOT: begin
                cmd.op   = OP_DOT;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    state_next = S_SCORE;
                end
            end
            S_SCORE: begin
                cmd.op     = OP_SCORE;
                state_next = S_IDLE;
            end
            S_EMIT: begin
                if (!st.out_full) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[hdl/cns_datapath.sv]
module cns_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  cns_pkg::cmd_t                           cmd,
    output cns_pkg::status_t                        st,
    input  logic                                    cfg_wr_en,
    input  logic [cns_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [cns_pkg::DATA_W-1:0]              cfg_wr_data,
    input  logic [1:0]                              s_func,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_contact_depth,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_contact_normal_x,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_contact_normal_y,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_contact_normal_z,
    input  logic                                    s_world_collided,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_requested_x,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_requested_y,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_requested_z,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_corrected_x,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_corrected_y,
    input  logic signed [cns_pkg::DATA_W-1:0]       s_corrected_z,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_blocking,
    output logic signed [cns_pkg::NORM_W-1:0]       m_push_normal_x,
    output logic signed [cns_pkg::NORM_W-1:0]       m_push_normal_y,
    output logic signed [cns_pkg::NORM_W-1:0]       m_push_normal_z,
    output logic [cns_pkg::DEPTH_W-1:0]             m_push_depth
);
    import cns_pkg::*;

    // configuration
    logic [DEPTH_W-1:0]       tol_reg;
    logic signed [DATA_W-1:0] motion_reg [3];

    // contact summary
    logic signed [NORM_W-1:0]  mdir_reg [3];
    logic                      seen_reg, have_reg;
    logic signed [DATA_W-1:0]  deepest_reg, lead_depth_reg;
    logic signed [SCORE_W-1:0] lead_score_reg;
    logic signed [NORM_W-1:0]  best_n_reg [3];

    // current item
    logic [1:0]               func_reg;
    logic signed [DATA_W-1:0] depth_reg;
    logic                     world_reg, big_reg;
    logic signed [VEC_W-1:0]  vec_reg [3];

    // arithmetic units
    logic [SQ_W-1:0]          prod_reg, acc_reg, sq_rem_reg, root_reg, bit_reg;
    logic [DVD_W-1:0]         dvd_reg, quo_reg;
    logic [ROOT_W-1:0]        rem_reg;
    logic signed [NORM_W-1:0] un_reg [3];
    logic signed [2*NORM_W-1:0] dprod_reg;
    logic signed [DOT_W-1:0]  dot_reg;

    // output register
    logic                     out_valid_reg, out_blk_reg;
    logic signed [NORM_W-1:0] out_n_reg [3];
    logic [DEPTH_W-1:0]       out_depth_reg;

    logic signed [VEC_W-1:0] diff_c [3];
    logic signed [VEC_W-1:0] half_c [3];
    logic                    big_c;
    logic signed [VEC_W-1:0] vsel;
    logic [VEC_W-1:0]        vmag;
    logic [ROOT_W-1:0]       len;
    logic [SQ_W-1:0]         sq_trial;
    logic [ROOT_W:0]         dv_trial;
    logic [DVD_W-1:0]        q_clamp;
    logic signed [NORM_W-1:0] mdsel, unsel;
    logic [DOT_W-1:0]        dot_mag;
    logic signed [DOT_W-1:0] dot_trunc;
    logic signed [SCORE_W-1:0] score;
    logic signed [SCORE_W:0] sdiff;
    logic                    take, mdir_nz;
    logic [ROOT_W:0]         full_len;
    logic [DEPTH_W-1:0]      full_sat;

    always_comb begin
        big_c = 1'b0;
        for (int i = 0; i < 3; i++) begin
            diff_c[i] = '0;
            half_c[i] = '0;
        end
        diff_c[0] = VEC_W'(s_corrected_x) - VEC_W'(s_requested_x);
        diff_c[1] = VEC_W'(s_corrected_y) - VEC_W'(s_requested_y);
        diff_c[2] = VEC_W'(s_corrected_z) - VEC_W'(s_requested_z);
        for (int i = 0; i < 3; i++) begin
            if (mag_f(diff_c[i]) >= VEC_W'(64'h8000_0000)) big_c = 1'b1;
            half_c[i] = $signed(diff_c[i] + VEC_W'(diff_c[i][VEC_W-1])) >>> 1;
        end
    end

    always_comb begin
        unique case (cmd.idx)
            2'd0:    begin vsel = vec_reg[0]; mdsel = mdir_reg[0]; unsel = un_reg[0]; end
            2'd1:    begin vsel = vec_reg[1]; mdsel = mdir_reg[1]; unsel = un_reg[1]; end
            2'd2:    begin vsel = vec_reg[2]; mdsel = mdir_reg[2]; unsel = un_reg[2]; end
            default: begin vsel = '0; mdsel = '0; unsel = '0; end
        endcase
        vmag     = mag_f(vsel);
        len      = root_reg[ROOT_W-1:0];
        sq_trial = root_reg + bit_reg;
        dv_trial = {rem_reg, dvd_reg[DVD_W-1]};
        q_clamp  = (len == '0) ? '0 : ((quo_reg > ONE_RAW) ? ONE_RAW : quo_reg);
        dot_mag  = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
        dot_trunc = dot_reg[DOT_W-1] ? -$signed(DOT_W'(dot_mag >> FRAC_BITS))
                                     : $signed(DOT_W'(dot_mag >> FRAC_BITS));
        mdir_nz  = (mdir_reg[0] != 0) || (mdir_reg[1] != 0) || (mdir_reg[2] != 0);
        score    = mdir_nz ? SCORE_W'(-dot_trunc) : SCORE_W'(depth_reg);
        sdiff    = (SCORE_W + 1)'(score) - (SCORE_W + 1)'(lead_score_reg);
        take     = !have_reg || (sdiff > SCORE_MARGIN) ||
                   ((sdiff >= -SCORE_MARGIN) && (depth_reg > lead_depth_reg));
        full_len = big_reg ? {len, 1'b0} : {1'b0, len};
        full_sat = (full_len > (ROOT_W + 1)'({DEPTH_W{1'b1}})) ? {DEPTH_W{1'b1}}
                                                               : full_len[DEPTH_W-1:0];
    end

    assign st.func           = func_reg;
    assign st.depth_neg      = depth_reg[DATA_W-1];
    assign st.depth_le_tol   = $signed({depth_reg[DATA_W-1], depth_reg}) <=
                               $signed({2'b00, tol_reg});
    assign st.world          = world_reg;
    assign st.seen           = seen_reg;
    assign st.deepest_le_tol = $signed({deepest_reg[DATA_W-1], deepest_reg}) <=
                               $signed({2'b00, tol_reg});
    assign st.have_blk       = have_reg;
    assign st.s_small        = acc_reg <= NEAR_ZERO_SQ;
    assign st.len_le_tol     = !big_reg && ({1'b0, len} <= (ROOT_W + 1)'(tol_reg));
    assign st.out_full       = out_valid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
            for (int i = 0; i < 3; i++) motion_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TOL:      tol_reg       <= cfg_wr_data[DEPTH_W-1:0];
                REG_MOTION_X: motion_reg[0] <= cfg_wr_data;
                REG_MOTION_Y: motion_reg[1] <= cfg_wr_data;
                REG_MOTION_Z: motion_reg[2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // summary state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 1'b0;
            have_reg       <= 1'b0;
            deepest_reg    <= '0;
            lead_depth_reg <= '0;
            lead_score_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                mdir_reg[i]   <= '0;
                best_n_reg[i] <= '0;
            end
        end else begin
            unique case (cmd.op)
                OP_BEGIN: begin
                    seen_reg       <= 1'b0;
                    have_reg       <= 1'b0;
                    deepest_reg    <= '0;
                    lead_depth_reg <= '0;
                    lead_score_reg <= '0;
                    for (int i = 0; i < 3; i++) begin
                        mdir_reg[i]   <= '0;
                        best_n_reg[i] <= '0;
                    end
                end
                OP_MARK: begin
                    seen_reg <= 1'b1;
                    if (depth_reg > deepest_reg) deepest_reg <= depth_reg;
                end
                OP_SET_MDIR: begin
                    for (int i = 0; i < 3; i++) mdir_reg[i] <= un_reg[i];
                end
                OP_SCORE: begin
                    if (take) begin
                        have_reg       <= 1'b1;
                        lead_score_reg <= score;
                        lead_depth_reg <= depth_reg;
                        for (int i = 0; i < 3; i++) best_n_reg[i] <= un_reg[i];
                    end
                end
                default: ;
            endcase
        end
    end

    // item capture and arithmetic units
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            depth_reg <= s_contact_depth;
            world_reg <= s_world_collided;
            big_reg   <= 1'b0;
            priority if (s_func == FUNC_BEGIN) begin
                for (int i = 0; i < 3; i++) vec_reg[i] <= VEC_W'(motion_reg[i]);
            end else if (s_func == FUNC_CONTACT) begin
                vec_reg[0] <= VEC_W'(s_contact_normal_x);
                vec_reg[1] <= VEC_W'(s_contact_normal_y);
                vec_reg[2] <= VEC_W'(s_contact_normal_z);
            end else begin
                big_reg <= big_c;
                for (int i = 0; i < 3; i++) vec_reg[i] <= big_c ? half_c[i] : diff_c[i];
            end
        end
        unique case (cmd.op)
            OP_SQ: begin
                prod_reg <= SQ_W'(vmag[ROOT_W-1:0]) * SQ_W'(vmag[ROOT_W-1:0]);
                acc_reg  <= (cmd.idx == 2'd0) ? '0 : acc_reg + prod_reg;
            end
            OP_SQRT_INIT: begin
                sq_rem_reg <= acc_reg;
                root_reg   <= '0;
                bit_reg    <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQRT_STEP: begin
                if (sq_rem_reg >= sq_trial) begin
                    sq_rem_reg <= sq_rem_reg - sq_trial;
                    root_reg   <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DIV_INIT: begin
                dvd_reg <= {vmag[ROOT_W-1:0], {FRAC_BITS{1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_DIV_STEP: begin
                dvd_reg <= dvd_reg << 1;
                if (dv_trial >= {1'b0, len}) begin
                    rem_reg <= ROOT_W'(dv_trial - {1'b0, len});
                    quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= dv_trial[ROOT_W-1:0];
                    quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
                end
            end
            OP_DIV_STORE: begin
                un_reg[cmd.idx] <= vsel[VEC_W-1] ? -$signed(NORM_W'(q_clamp))
                                                 : $signed(NORM_W'(q_clamp));
            end
            OP_DOT: begin
                dprod_reg <= mdsel * unsel;
                dot_reg   <= (cmd.idx == 2'd0) ? '0 : dot_reg + DOT_W'(dprod_reg);
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            unique case (cmd.emit_kind)
                EMIT_BEST: begin
                    out_blk_reg   <= 1'b1;
                    out_depth_reg <= lead_depth_reg[DEPTH_W-1:0];
                    for (int i = 0; i < 3; i++) out_n_reg[i] <= best_n_reg[i];
                end
                EMIT_UNIT: begin
                    out_blk_reg   <= 1'b1;
                    out_depth_reg <= full_sat;
                    for (int i = 0; i < 3; i++) out_n_reg[i] <= un_reg[i];
                end
                EMIT_BLK_ZERO: begin
                    out_blk_reg   <= 1'b1;
                    out_depth_reg <= '0;
                    for (int i = 0; i < 3; i++) out_n_reg[i] <= '0;
                end
                default: begin
                    out_blk_reg   <= 1'b0;
                    out_depth_reg <= '0;
                    for (int i = 0; i < 3; i++) out_n_reg[i] <= '0;
                end
            endcase
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_blocking      = out_blk_reg;
    assign m_push_normal_x = out_n_reg[0];
    assign m_push_normal_y = out_n_reg[1];
    assign m_push_normal_z = out_n_reg[2];
    assign m_push_depth    = out_depth_reg;

endmodule

[hdl/cns_checker.sv]
`include "contact_normal_selector_assert.svh"

module cns_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_blocking,
    input logic signed [cns_pkg::NORM_W-1:0]  m_push_normal_x,
    input logic signed [cns_pkg::NORM_W-1:0]  m_push_normal_y,
    input logic signed [cns_pkg::NORM_W-1:0]  m_push_normal_z,
    input logic [cns_pkg::DEPTH_W-1:0]        m_push_depth
);
    import cns_pkg::*;

    `CNS_ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `CNS_ASSERT_IMPL(a_clear_zero, aclk, aresetn, m_valid && !m_blocking, m_push_normal_x == 0 && m_push_normal_y == 0 && m_push_normal_z == 0 && m_push_depth == 0, "non-blocking result not zero")
    `CNS_ASSERT_IMPL(a_unit_range, aclk, aresetn, m_valid, m_push_normal_x <= $signed(NORM_W'(ONE_RAW)) && m_push_normal_x >= -$signed(NORM_W'(ONE_RAW)), "normal out of unit range")
    `CNS_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted twice in a row")

endmodule

bind contact_normal_selector cns_checker u_cns_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_blocking      (m_blocking),
    .m_push_normal_x (m_push_normal_x),
    .m_push_normal_y (m_push_normal_y),
    .m_push_normal_z (m_push_normal_z),
    .m_push_depth    (m_push_depth)
);

[verif/tb_top.sv]
module tb_top;
    import cns_pkg::*;

    // one input item as offered on the s_ channel
    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] depth;
        logic signed [31:0] nrm [3];
        logic               world;
        logic signed [31:0] req [3];
        logic signed [31:0] cor [3];
    } item_t;

    // one blocking decision as seen on the m_ channel
    typedef struct {
        logic                     blocking;
        logic [NORM_W-1:0]        nrm [3];
        logic [DEPTH_W-1:0]       depth;
    } decision_t;

    typedef longint vec_t [3];

    localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
    localparam longint DEPTH_SAT = 64'h7FFF_FFFF;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [DATA_W-1:0]             cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_func = '0;
    logic signed [DATA_W-1:0]      s_contact_depth = '0;
    logic signed [DATA_W-1:0]      s_contact_normal_x = '0;
    logic signed [DATA_W-1:0]      s_contact_normal_y = '0;
    logic signed [DATA_W-1:0]      s_contact_normal_z = '0;
    logic                          s_world_collided = 1'b0;
    logic signed [DATA_W-1:0]      s_requested_x = '0;
    logic signed [DATA_W-1:0]      s_requested_y = '0;
    logic signed [DATA_W-1:0]      s_requested_z = '0;
    logic signed [DATA_W-1:0]      s_corrected_x = '0;
    logic signed [DATA_W-1:0]      s_corrected_y = '0;
    logic signed [DATA_W-1:0]      s_corrected_z = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_blocking;
    logic signed [NORM_W-1:0]      m_push_normal_x;
    logic signed [NORM_W-1:0]      m_push_normal_y;
    logic signed [NORM_W-1:0]      m_push_normal_z;
    logic [DEPTH_W-1:0]            m_push_depth;

    contact_normal_selector uut (.*);

    // 10 unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus waiting for the driver, decisions waiting for the monitor
    item_t     pending_items [$];
    decision_t decisions_due [$];
    int        fail_count = 0;
    int        decisions_seen = 0;

    // predictor copy of the register file and the contact summary
    longint tol_q;
    vec_t   motion_q;
    vec_t   motion_dir;
    bit     seen_contact;
    longint deepest;
    bit     have_blocking;
    longint lead_score;
    longint lead_depth;
    vec_t   lead_normal;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned square_sum(vec_t v);
        longint unsigned s, m;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = magnitude(v[i]);
            s = s + m * m;
        end
        return s;
    endfunction

    // unit vector in raw units, truncated and clamped to one
    function automatic vec_t unit_of(vec_t v, longint unsigned s);
        vec_t o;
        longint unsigned len, q;
        len = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (len == 0) ? 0 : (magnitude(v[i]) << FRAC_BITS) / len;
            if (q > ONE_Q) q = ONE_Q;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    function automatic decision_t make_decision(bit blk, vec_t n, longint d);
        decision_t r;
        r.blocking = blk;
        for (int i = 0; i < 3; i++) r.nrm[i] = NORM_W'(n[i]);
        r.depth = DEPTH_W'(d);
        return r;
    endfunction

    // update the contact summary for one accepted transfer, queue any decision
    task automatic predict_item(item_t it);
        vec_t   v, u, zero;
        longint unsigned s, len;
        longint dep, score, p, diff, full;
        bit     big, take;
        zero = '{0, 0, 0};
        case (it.func)
            FUNC_BEGIN: begin
                s = square_sum(motion_q);
                seen_contact = 0;
                deepest = 0;
                have_blocking = 0;
                lead_score = 0;
                lead_depth = 0;
                lead_normal = zero;
                motion_dir = zero;
                if (s > NEAR_ZERO_SQ) motion_dir = unit_of(motion_q, s);
            end
            FUNC_CONTACT: begin
                dep = it.depth;
                if (dep >= 0) begin
                    seen_contact = 1;
                    if (dep > deepest) deepest = dep;
                    for (int i = 0; i < 3; i++) v[i] = it.nrm[i];
                    s = square_sum(v);
                    if (dep > tol_q && s > NEAR_ZERO_SQ) begin
                        u = unit_of(v, s);
                        if (motion_dir[0] != 0 || motion_dir[1] != 0 || motion_dir[2] != 0) begin
                            p = 0;
                            for (int i = 0; i < 3; i++) p = p + motion_dir[i] * u[i];
                            score = -(p / ONE_Q);
                        end else begin
                            score = dep;
                        end
                        diff = score - lead_score;
                        take = !have_blocking || diff > longint'(SCORE_MARGIN) ||
                            (diff <= longint'(SCORE_MARGIN) &&
                             diff >= -longint'(SCORE_MARGIN) && dep > lead_depth);
                        if (take) begin
                            lead_score = score;
                            lead_depth = dep;
                            lead_normal = u;
                            have_blocking = 1;
                        end
                    end
                end
            end
            FUNC_RESOLVE: begin
                if (!it.world) begin
                    decisions_due.push_back(make_decision(0, zero, 0));
                end else if (seen_contact && deepest <= tol_q) begin
                    decisions_due.push_back(make_decision(0, zero, 0));
                end else if (seen_contact && have_blocking) begin
                    decisions_due.push_back(make_decision(1, lead_normal, lead_depth));
                end else begin
                    // fallback from the solver correction
                    big = 0;
                    for (int i = 0; i < 3; i++) begin
                        v[i] = longint'(it.cor[i]) - longint'(it.req[i]);
                        if (magnitude(v[i]) >= 64'h8000_0000) big = 1;
                    end
                    if (big) for (int i = 0; i < 3; i++) v[i] = v[i] / 2;
                    s = square_sum(v);
                    len = isqrt(s);
                    if (big) len = len << 1;
                    full = (len > DEPTH_SAT) ? DEPTH_SAT : longint'(len);
                    if (!big && longint'(len) <= tol_q)
                        decisions_due.push_back(make_decision(0, zero, 0));
                    else if (s > NEAR_ZERO_SQ)
                        decisions_due.push_back(make_decision(1, unit_of(v, s), full));
                    else
                        decisions_due.push_back(make_decision(1, zero, 0));
                end
            end
            default: ;  // unused code, ignored
        endcase
    endtask

    // driver: bursts of transfers with random gaps between them
    item_t cur_item;
    int    burst_left = 0;
    int    gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_item(cur_item);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_func <= cur_item.func;
                s_contact_depth <= cur_item.depth;
                s_contact_normal_x <= cur_item.nrm[0];
                s_contact_normal_y <= cur_item.nrm[1];
                s_contact_normal_z <= cur_item.nrm[2];
                s_world_collided <= cur_item.world;
                s_requested_x <= cur_item.req[0];
                s_requested_y <= cur_item.req[1];
                s_requested_z <= cur_item.req[2];
                s_corrected_x <= cur_item.cor[0];
                s_corrected_y <= cur_item.cor[1];
                s_corrected_z <= cur_item.cor[2];
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: own stall pattern plus one long hold-off to back the block up
    int  stall_left = 0;
    int  run_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    decision_t due;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            decisions_seen <= decisions_seen + 1;
            if (decisions_due.size() == 0) begin
                $error("decision with nothing expected");
                fail_count++;
            end else begin
                due = decisions_due.pop_front();
                if (m_blocking !== due.blocking) begin
                    $error("blocking expected %0d got %0d", due.blocking, m_blocking);
                    fail_count++;
                end
                if (m_push_normal_x !== due.nrm[0]) begin
                    $error("push_normal_x expected %0d got %0d",
                           $signed(due.nrm[0]), m_push_normal_x);
                    fail_count++;
                end
                if (m_push_normal_y !== due.nrm[1]) begin
                    $error("push_normal_y expected %0d got %0d",
                           $signed(due.nrm[1]), m_push_normal_y);
                    fail_count++;
                end
                if (m_push_normal_z !== due.nrm[2]) begin
                    $error("push_normal_z expected %0d got %0d",
                           $signed(due.nrm[2]), m_push_normal_z);
                    fail_count++;
                end
                if (m_push_depth !== due.depth) begin
                    $error("push_depth expected %0d got %0d", due.depth, m_push_depth);
                    fail_count++;
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && decisions_seen == 40) begin
            // long hold-off while the sender keeps offering
            hold_done <= 1;
            hold_left <= 4000;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
            m_ready <= 1'b1;
        end else begin
            run_left <= $urandom_range(0, 30);
            stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        if (idx == REG_TOL) tol_q = longint'(data[30:0]);
        else motion_q[idx - 1] = longint'($signed(data));
    endtask

    task automatic set_regs(logic [31:0] tol, logic [31:0] mx, logic [31:0] my,
                            logic [31:0] mz);
        write_reg(REG_TOL, tol);
        write_reg(REG_MOTION_X, mx);
        write_reg(REG_MOTION_Y, my);
        write_reg(REG_MOTION_Z, mz);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for all decisions, then let any silent work finish
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || decisions_due.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic item_t blank(logic [1:0] f);
        item_t it;
        it.func = f;
        it.depth = 0;
        it.world = 1'b1;
        for (int i = 0; i < 3; i++) begin
            it.nrm[i] = 0;
            it.req[i] = 0;
            it.cor[i] = 0;
        end
        return it;
    endfunction

    function automatic logic [31:0] rand_signed_small(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic item_t rand_contact();
        item_t it;
        int    k;
        it = blank(FUNC_CONTACT);
        case ($urandom_range(0, 9))
            0: it.depth = $urandom;
            1: it.depth = -$urandom_range(1, 1000);
            default: it.depth = $urandom_range(0, 1 << 20);
        endcase
        k = $urandom_range(0, 5);
        for (int i = 0; i < 3; i++) begin
            if (k == 0) it.nrm[i] = $urandom;
            else if (k == 1) it.nrm[i] = (i == 0) ? rand_signed_small(1 << 18) : 0;
            else it.nrm[i] = rand_signed_small(1 << 17);
        end
        it.world = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic item_t rand_resolve();
        item_t it;
        it = blank(FUNC_RESOLVE);
        it.world = ($urandom_range(0, 5) != 0);
        for (int i = 0; i < 3; i++) begin
            it.req[i] = $urandom;
            case ($urandom_range(0, 5))
                0: it.cor[i] = $urandom;
                1: it.cor[i] = it.req[i];
                default: it.cor[i] = it.req[i] + rand_signed_small(1 << 18);
            endcase
        end
        it.nrm[0] = $urandom;
        it.depth = $urandom;
        return it;
    endfunction

    function automatic item_t rand_noise();
        item_t it;
        it.func = $urandom_range(0, 3);
        it.depth = $urandom;
        it.world = $urandom_range(0, 1);
        for (int i = 0; i < 3; i++) begin
            it.nrm[i] = $urandom;
            it.req[i] = $urandom;
            it.cor[i] = $urandom;
        end
        return it;
    endfunction

    // mostly well-formed contact sets: begin, contacts, resolve
    task automatic queue_random(int n);
        int count;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 9) < 8) begin
                pending_items.push_back(blank(FUNC_BEGIN));
                repeat ($urandom_range(0, 6)) begin
                    pending_items.push_back(rand_contact());
                    count++;
                end
                pending_items.push_back(rand_resolve());
                count = count + 2;
            end else begin
                pending_items.push_back(rand_noise());
                count++;
            end
        end
    endtask

    task automatic queue_directed();
        item_t it;
        // resolve with no world collision
        it = blank(FUNC_RESOLVE);
        it.world = 1'b0;
        pending_items.push_back(it);
        // fallback with zero correction, within tolerance
        pending_items.push_back(blank(FUNC_RESOLVE));
        // fallback with huge correction, halved path
        it = blank(FUNC_RESOLVE);
        for (int i = 0; i < 3; i++) begin
            it.req[i] = 32'h8000_0000;
            it.cor[i] = 32'h7FFF_FFFF;
        end
        pending_items.push_back(it);
        // opposite extremes
        for (int i = 0; i < 3; i++) begin
            it.req[i] = 32'h7FFF_FFFF;
            it.cor[i] = 32'h8000_0000;
        end
        pending_items.push_back(it);
        // shallow contact only
        pending_items.push_back(blank(FUNC_BEGIN));
        it = blank(FUNC_CONTACT);
        it.nrm[2] = 32'h0001_0000;
        pending_items.push_back(it);
        pending_items.push_back(blank(FUNC_RESOLVE));
        // negative depth ignored, zero normal, extreme normals, a near tie
        pending_items.push_back(blank(FUNC_BEGIN));
        it = blank(FUNC_CONTACT);
        it.depth = 32'h8000_0000;
        it.nrm[0] = 32'h0001_0000;
        pending_items.push_back(it);
        it.depth = 32'h0000_1000;
        it.nrm[0] = 0;
        pending_items.push_back(it);
        it.depth = 32'h7FFF_FFFF;
        it.nrm[0] = 32'h8000_0000;
        it.nrm[1] = 32'h8000_0000;
        it.nrm[2] = 32'h7FFF_FFFF;
        pending_items.push_back(it);
        it.depth = 32'h7FFF_FFFF;
        it.nrm[0] = 32'h0001_0000;
        it.nrm[1] = 0;
        it.nrm[2] = 0;
        pending_items.push_back(it);
        it.depth = 32'h0001_0000;
        it.nrm[0] = 0;
        it.nrm[1] = 32'hFFFF_0000;
        pending_items.push_back(it);
        // unused code between contacts and resolve
        it = rand_noise();
        it.func = 2'd3;
        pending_items.push_back(it);
        pending_items.push_back(blank(FUNC_RESOLVE));
    endtask

    initial begin
        tol_q = 0;
        motion_q = '{0, 0, 0};
        motion_dir = '{0, 0, 0};
        lead_normal = '{0, 0, 0};
        seen_contact = 0;
        deepest = 0;
        have_blocking = 0;
        lead_score = 0;
        lead_depth = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // zero tolerance, no motion: directed corners then random
        set_regs(32'd0, 32'd0, 32'd0, 32'd0);
        queue_directed();
        queue_random(120);
        drain();
        // largest tolerance, most negative motion
        set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_directed();
        queue_random(100);
        drain();
        // top bit of the tolerance data is dropped; most positive motion on x
        set_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
        queue_random(60);
        drain();
        // small tolerances with random motion, the bulk of the run
        repeat (4) begin
            set_regs($urandom_range(0, 1 << 17), rand_signed_small(1 << 18),
                     rand_signed_small(1 << 18), $urandom);
            queue_random(130);
            drain();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
